/* rtl/lad_pkg.sv */
package lad_pkg;

    // Configuration register map
    localparam int NUM_COEFS = 3;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SHORT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MEDIUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LONG   = 2'd2;

    localparam int COEF_W = 16;
    localparam logic [COEF_W-1:0] COEF_SHORT_RST  = 16'd1083;
    localparam logic [COEF_W-1:0] COEF_MEDIUM_RST = 16'd218;
    localparam logic [COEF_W-1:0] COEF_LONG_RST   = 16'd73;

    // Input word command codes
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam int SUM_W  = 32;
    localparam int LOAD_W = 16;
    localparam int PEND_W = 16;
    localparam int AVG_W  = 27;
    localparam logic [LOAD_W-1:0] LOAD_MAX    = 16'hffff;
    localparam logic [PEND_W-1:0] PENDING_MAX = 16'hffff;

    localparam int FRAC_SHIFT_DEF   = 11;
    localparam int NUM_AVERAGES_DEF = 3;

    // Controller to datapath
    typedef struct packed {
        logic tick_inc;
        logic load_capture;
        logic update_en;
        logic sec_dec;
        logic out_load;
    } lad_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pending_zero;
        logic pending_one;
        logic out_free;
    } lad_status_t;

endpackage

/* rtl/lad_ctrl.sv */
module lad_ctrl
    import lad_pkg::*;
#(
    parameter int NUM_AVERAGES = NUM_AVERAGES_DEF,
    parameter int IDX_W        = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  lad_status_t      status,
    output lad_cmd_t         ctl,
    output logic [IDX_W-1:0] avg_idx
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_AVERAGES - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign avg_idx = idx_reg;

    // Sequence one average per cycle, one second per pass over the averages
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_TICK) begin
                        ctl.tick_inc = 1'b1;
                    end else begin
                        ctl.load_capture = 1'b1;
                        idx_next         = '0;
                        state_next       = status.pending_zero ? ST_DONE : ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                ctl.update_en = 1'b1;
                if (idx_reg == IDX_LAST) begin
                    idx_next    = '0;
                    ctl.sec_dec = 1'b1;
                    if (status.pending_one) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (status.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* rtl/lad_datapath.sv */
module lad_datapath
    import lad_pkg::*;
#(
    parameter int FRAC_SHIFT   = FRAC_SHIFT_DEF,
    parameter int NUM_AVERAGES = NUM_AVERAGES_DEF,
    parameter int IDX_W        = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_wr_data,
    input  logic [31:0]          s_load_sample,
    input  lad_cmd_t             ctl,
    input  logic [IDX_W-1:0]     avg_idx,
    output lad_status_t          status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [AVG_W-1:0]     m_avg_short,
    output logic [AVG_W-1:0]     m_avg_medium,
    output logic [AVG_W-1:0]     m_avg_long
);

    localparam int OUT_SH = 16 - FRAC_SHIFT;

    logic [COEF_W-1:0] coef_short_reg, coef_medium_reg, coef_long_reg;
    logic [SUM_W-1:0]  sum_reg [NUM_AVERAGES];
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [LOAD_W-1:0] load_reg;
    logic              m_valid_reg;
    logic [AVG_W-1:0]  avg_reg [3];

    logic [1:0]          sel;
    logic [COEF_W-1:0]   coef_sel;
    logic [SUM_W-1:0]    sum_sel, sum_new;
    logic signed [16:0]  diff;
    logic signed [33:0]  up_full;
    logic [31:0]         down_full;
    logic [SUM_W-1:0]    up;

    // Coefficient registers, writes beyond the map are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_short_reg  <= COEF_SHORT_RST;
            coef_medium_reg <= COEF_MEDIUM_RST;
            coef_long_reg   <= COEF_LONG_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COEF_SHORT:  coef_short_reg  <= cfg_wr_data;
                REG_COEF_MEDIUM: coef_medium_reg <= cfg_wr_data;
                REG_COEF_LONG:   coef_long_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Select the coefficient of the average being updated
    assign sel = 2'(avg_idx);
    always_comb begin
        unique case (sel)
            2'd0:    coef_sel = coef_short_reg;
            2'd1:    coef_sel = coef_medium_reg;
            2'd2:    coef_sel = coef_long_reg;
            default: coef_sel = '0;
        endcase
    end

    // Shared decay unit: s += (n - q) * f - ((r * f) >> 16), modulo 2^32
    assign sum_sel   = sum_reg[avg_idx];
    assign diff      = signed'({1'b0, load_reg}) - signed'({1'b0, sum_sel[31:16]});
    assign up_full   = diff * signed'({1'b0, coef_sel});
    assign up        = up_full[31:0];
    assign down_full = sum_sel[15:0] * coef_sel;
    assign sum_new   = sum_sel + up - {16'd0, down_full[31:16]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AVERAGES; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (ctl.update_en) begin
            sum_reg[avg_idx] <= sum_new;
        end
    end

    // Clamp and hold the load for the whole catch-up
    always_ff @(posedge aclk) begin
        if (ctl.load_capture) begin
            load_reg <= (|s_load_sample[31:16]) ? LOAD_MAX : s_load_sample[15:0];
        end
    end

    // Pending seconds: saturating count up on tick, count down per finished second
    always_comb begin
        pending_next = pending_reg;
        if (ctl.tick_inc && (pending_reg != PENDING_MAX)) begin
            pending_next = pending_reg + 1'b1;
        end else if (ctl.sec_dec) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= PEND_W'(1);
        end else begin
            pending_reg <= pending_next;
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_avg
        if (g < NUM_AVERAGES) begin : g_used
            logic [SUM_W-1:0] shifted;
            assign shifted = sum_reg[g] >> OUT_SH;
            always_ff @(posedge aclk) begin
                if (ctl.out_load) begin
                    avg_reg[g] <= shifted[AVG_W-1:0];
                end
            end
        end else begin : g_unused
            always_ff @(posedge aclk) begin
                avg_reg[g] <= '0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_avg_short  = avg_reg[0];
    assign m_avg_medium = avg_reg[1];
    assign m_avg_long   = avg_reg[2];

    assign status.pending_zero = (pending_reg == '0);
    assign status.pending_one  = (pending_reg == PEND_W'(1));
    assign status.out_free     = !m_valid_reg || m_ready;

endmodule

/* rtl/load_average_decay_filter.sv */
// Exponentially decayed load averages (1, 5 and 15 minute windows) kept as
// 16.16 fixed-point sums. A tick word counts one elapsed second (saturating
// at 65535). For a sample word the load is captured, then a single shared
// decay unit updates one average per cycle, once per pending second,
// before the result is loaded into the output register. Results are the
// sums shifted down to FRAC_SHIFT fraction bits; averages beyond
// NUM_AVERAGES read as zero. Coefficients must be written through the cfg
// port only while the block is idle; the block does not enforce this.
module load_average_decay_filter
    import lad_pkg::*;
#(
    parameter int FRAC_SHIFT   = FRAC_SHIFT_DEF,
    parameter int NUM_AVERAGES = NUM_AVERAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [31:0]          s_load_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [AVG_W-1:0]     m_avg_short,
    output logic [AVG_W-1:0]     m_avg_medium,
    output logic [AVG_W-1:0]     m_avg_long
);

    localparam int IDX_W = (NUM_AVERAGES > 1) ? $clog2(NUM_AVERAGES) : 1;

    lad_cmd_t         ctl;
    lad_status_t      status;
    logic [IDX_W-1:0] avg_idx;

    lad_ctrl #(
        .NUM_AVERAGES (NUM_AVERAGES),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .status  (status),
        .ctl     (ctl),
        .avg_idx (avg_idx)
    );

    lad_datapath #(
        .FRAC_SHIFT   (FRAC_SHIFT),
        .NUM_AVERAGES (NUM_AVERAGES),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_load_sample (s_load_sample),
        .ctl           (ctl),
        .avg_idx       (avg_idx),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_avg_short   (m_avg_short),
        .m_avg_medium  (m_avg_medium),
        .m_avg_long    (m_avg_long)
    );

endmodule
